// ===== rtl/sphp_pkg.sv =====
// shared types and constants for the sensor peak history plotter
// no dependencies; imported by every rtl module of the block
package sphp_pkg;

  localparam int COL_W  = 7;
  localparam int DIV_DW = 30;
  localparam int DIV_VW = 16;

  typedef struct packed {
    logic                 kind;
    logic [9:0]           adc_sample;
    logic [COL_W-1:0]     column_index;
  } item_t;

  typedef struct packed {
    logic signed [15:0]   pressure;
    logic [14:0]          peak_max;
    logic signed [15:0]   peak_min;
    logic [7:0]           column_x;
    logic [7:0]           column_y;
    logic [7:0]           zero_line_y;
    logic                 fill_column;
    logic                 range_zero;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DW-1:0]    dividend;
    logic [DIV_VW-1:0]    divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_NUM,
    ST_PDIV,
    ST_PFIN,
    ST_IDX,
    ST_RD,
    ST_ZDIV,
    ST_VDIV,
    ST_CFIN
  } state_t;

  localparam logic [2:0] CFG_SENSOR_ZERO = 3'd0;
  localparam logic [2:0] CFG_FULL_SCALE  = 3'd1;
  localparam logic [2:0] CFG_SPAN_TENTHS = 3'd2;
  localparam logic [2:0] CFG_PLOT_TOP    = 3'd3;
  localparam logic [2:0] CFG_PLOT_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_PLOT_WIDTH  = 3'd5;

  localparam logic [9:0]  RST_SENSOR_ZERO = 10'd151;
  localparam logic [15:0] RST_FULL_SCALE  = 16'd6000;
  localparam logic [13:0] RST_SPAN_TENTHS = 14'd7706;
  localparam logic [7:0]  RST_PLOT_TOP    = 8'd32;
  localparam logic [7:0]  RST_PLOT_HEIGHT = 8'd31;
  localparam logic [7:0]  RST_PLOT_WIDTH  = 8'd128;

  localparam logic signed [15:0] P_MAX = 16'sh7FFF;
  localparam logic signed [15:0] P_MIN = 16'sh8000;

endpackage

// ===== rtl/sphp_div.sv =====
// unsigned restoring divider, two quotient bits per cycle
// depends on sphp_pkg for the request struct and operand widths
module sphp_div import sphp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              done,
  output logic [DIV_DW-1:0] quotient
);

  localparam int STEPS  = 2;
  localparam int CYCLES = (DIV_DW + STEPS - 1) / STEPS;
  localparam int CW     = $clog2(CYCLES);

  logic [DIV_VW:0]   rem, rem_next;
  logic [DIV_DW-1:0] shq, shq_next;
  logic [DIV_VW-1:0] dsr;
  logic [CW-1:0]     cnt;
  logic              run;

  // dividend shifts out of the top of shq while quotient bits enter below
  always_comb begin
    rem_next = rem;
    shq_next = shq;
    for (int i = 0; i < STEPS; i++) begin
      rem_next = {rem_next[DIV_VW-1:0], shq_next[DIV_DW-1]};
      shq_next = {shq_next[DIV_DW-2:0], 1'b0};
      if (rem_next >= {1'b0, dsr}) begin
        rem_next    = rem_next - {1'b0, dsr};
        shq_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CW'(CYCLES - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      shq <= req.dividend;
      dsr <= req.divisor;
    end else if (run) begin
      rem <= rem_next;
      shq <= shq_next;
    end
  end

  assign quotient = shq;

endmodule

// ===== rtl/sensor_peak_history_plotter.sv =====
// sample item: one division in the shared divider from request to result, skipped
// when span_tenths is zero
// column item: two divisions, after one step per history-depth wrap of the address;
// the divisions are skipped when the peak range is zero; one item is in work at a time
// sync reset restores register defaults, empties history (unwritten entries read zero)
// and clears peaks; no clearing pass, ready as soon as reset drops
module sensor_peak_history_plotter import sphp_pkg::*; #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int IW = $clog2(HISTORY_DEPTH + (1 << COL_W));

  state_t state, state_next;

  logic [9:0]  sensor_zero;
  logic [15:0] full_scale;
  logic [13:0] span_tenths;
  logic [7:0]  plot_top, plot_height, plot_width;

  logic [AW-1:0]      wp;
  logic               full;
  logic signed [15:0] rmax, rmin;

  logic [9:0]         smp;
  logic [COL_W-1:0]   col;
  logic signed [27:0] prod;
  logic               num_neg;
  logic signed [15:0] pval;
  logic [IW-1:0]      idx;
  logic [15:0]        mem [HISTORY_DEPTH];
  logic [15:0]        rd_data;
  logic               rd_ok;
  logic [23:0]        vnum;
  logic [9:0]         zq, vq;
  logic               rz;

  div_req_t          div_req;
  logic              div_done;
  logic [DIV_DW-1:0] div_q;

  logic mem_re, mem_we, res_load;

  logic signed [10:0] diff;
  logic signed [31:0] num;
  logic [31:0]        num_abs;
  logic [15:0]        absmin, range;
  logic signed [15:0] vsel;
  logic signed [16:0] vsum;
  logic [23:0]        znum;
  logic [9:0]         row_base;
  logic signed [10:0] row_v, row_z;
  logic signed [15:0] new_max, new_min;
  result_t            res_next;

  sphp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // datapath arithmetic
  always_comb begin
    diff     = $signed({1'b0, smp}) - $signed({1'b0, sensor_zero});
    num      = (32'(prod) <<< 3) + (32'(prod) <<< 1);
    num_abs  = num[31] ? 32'(-num) : 32'(num);
    absmin   = -rmin;
    range    = absmin + {1'b0, rmax[14:0]};
    vsel     = rd_ok ? $signed(rd_data) : 16'sd0;
    vsum     = {vsel[15], vsel} + $signed({1'b0, absmin});
    znum     = absmin * plot_height;
    row_base = {2'b0, plot_top} + {2'b0, plot_height};
    row_z    = rz ? $signed({1'b0, row_base}) : $signed({1'b0, row_base}) - $signed({1'b0, zq});
    row_v    = rz ? $signed({1'b0, row_base}) : $signed({1'b0, row_base}) - $signed({1'b0, vq});
    new_max  = (pval > rmax) ? pval : rmax;
    new_min  = (pval < rmin) ? pval : rmin;
  end

  always_comb begin
    res_next = '0;
    if (state == ST_PFIN) begin
      res_next.pressure = pval;
      res_next.peak_max = new_max[14:0];
      res_next.peak_min = new_min;
    end else begin
      res_next.peak_max    = rmax[14:0];
      res_next.peak_min    = rmin;
      res_next.column_x    = plot_width - {1'b0, col};
      res_next.column_y    = row_v[7:0];
      res_next.zero_line_y = row_z[7:0];
      res_next.fill_column = row_v < row_z;
      res_next.range_zero  = rz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    div_req    = '0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    res_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = !rst;
        if (item_valid) begin
          state_next = item.kind ? ST_IDX : ST_MUL;
        end
      end
      ST_MUL: state_next = ST_NUM;
      ST_NUM: begin
        if (span_tenths == '0) begin
          state_next = ST_PFIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = num_abs[DIV_DW-1:0];
          div_req.divisor  = DIV_VW'(span_tenths);
          state_next       = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (div_done) begin
          state_next = ST_PFIN;
        end
      end
      ST_PFIN: begin
        if (!result_valid || result_ready) begin
          res_load   = 1'b1;
          mem_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_IDX: begin
        // wrap the age-relative address one depth at a time
        if (idx < IW'(HISTORY_DEPTH)) begin
          mem_re     = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        if (range == '0) begin
          state_next = ST_CFIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_DW'(znum);
          div_req.divisor  = range;
          state_next       = ST_ZDIV;
        end
      end
      ST_ZDIV: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_DW'(vnum);
          div_req.divisor  = range;
          state_next       = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (div_done) begin
          state_next = ST_CFIN;
        end
      end
      ST_CFIN: begin
        if (!result_valid || result_ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_zero <= RST_SENSOR_ZERO;
      full_scale  <= RST_FULL_SCALE;
      span_tenths <= RST_SPAN_TENTHS;
      plot_top    <= RST_PLOT_TOP;
      plot_height <= RST_PLOT_HEIGHT;
      plot_width  <= RST_PLOT_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSOR_ZERO: sensor_zero <= cfg_data[9:0];
        CFG_FULL_SCALE:  full_scale  <= cfg_data;
        CFG_SPAN_TENTHS: span_tenths <= cfg_data[13:0];
        CFG_PLOT_TOP:    plot_top    <= cfg_data[7:0];
        CFG_PLOT_HEIGHT: plot_height <= cfg_data[7:0];
        CFG_PLOT_WIDTH:  plot_width  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // history control and peaks; an entry is written once full or above wp
  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= AW'(HISTORY_DEPTH - 1);
      full         <= 1'b0;
      rmax         <= '0;
      rmin         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (mem_we) begin
        rmax <= new_max;
        rmin <= new_min;
        if (wp == '0) begin
          wp   <= AW'(HISTORY_DEPTH - 1);
          full <= 1'b1;
        end else begin
          wp <= wp - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
    if (state == ST_IDLE && item_valid) begin
      smp <= item.adc_sample;
      col <= item.column_index;
      idx <= IW'(item.column_index) + IW'(wp);
    end
    case (state)
      ST_MUL: prod <= 28'(diff) * 28'($signed({1'b0, full_scale}));
      ST_NUM: begin
        num_neg <= num[31];
        if (num > 0) begin
          pval <= P_MAX;
        end else if (num < 0) begin
          pval <= P_MIN;
        end else begin
          pval <= '0;
        end
      end
      ST_PDIV: begin
        if (div_done) begin
          if (!num_neg) begin
            pval <= (div_q > DIV_DW'(32767)) ? P_MAX : $signed(div_q[15:0]);
          end else begin
            pval <= (div_q > DIV_DW'(32768)) ? P_MIN : -$signed(div_q[15:0]);
          end
        end
      end
      ST_IDX: begin
        if (idx >= IW'(HISTORY_DEPTH)) begin
          idx <= idx - IW'(HISTORY_DEPTH);
        end else begin
          rd_ok <= full || (idx > IW'(wp));
        end
      end
      ST_RD: begin
        rz   <= (range == '0);
        vnum <= vsum[15:0] * plot_height;
      end
      ST_ZDIV: begin
        if (div_done) begin
          zq <= div_q[9:0];
        end
      end
      ST_VDIV: begin
        if (div_done) begin
          vq <= div_q[9:0];
        end
      end
      default: ;
    endcase
  end

  // history memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= pval;
    end
    if (mem_re) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

endmodule

// ===== rtl/sphp_check.sv =====
// port-level checks for the sensor peak history plotter, with the bind that attaches them
// depends on sphp_pkg and the top level's ports
module sphp_check import sphp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input result_t     result
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before it was taken");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result changed while stalled");

  a_peaks_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed(result.pressure) <= $signed({1'b0, result.peak_max}))
                  && ($signed(result.pressure) >= result.peak_min)
                  && (result.peak_min[15] || result.peak_min == 16'sd0))
    else $error("pressure outside the reported peaks");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.range_zero |->
      !result.fill_column && result.column_y == result.zero_line_y)
    else $error("flat range result inconsistent");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind sensor_peak_history_plotter sphp_check u_sphp_check (.*);
